[src/snapshot_versioned_array_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef SNAPSHOT_VERSIONED_ARRAY_MACROS_SVH
`define SNAPSHOT_VERSIONED_ARRAY_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SVA_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("snapshot array: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SVA_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("snapshot array: next-cycle check failed");

`endif

[src/sva_pkg.sv]
package sva_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int MAX_VERSIONS = 16;
    localparam int VALUE_BITS   = 32;
    localparam int SNAP_BITS    = 16;

    localparam int IDX_BITS  = $clog2(MAX_ENTRIES);
    localparam int VER_BITS  = $clog2(MAX_VERSIONS);
    localparam int CNT_BITS  = $clog2(MAX_VERSIONS + 1);
    localparam int SLOT_BITS = IDX_BITS + VER_BITS;
    localparam int SLOTS     = MAX_ENTRIES * MAX_VERSIONS;
    localparam int SLOT_W    = SNAP_BITS + VALUE_BITS;
    localparam int LEN_BITS  = 9;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(256);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SNAP  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_FUTURE = 3'd3;
    localparam logic [2:0] ST_SAT    = 3'd4;

    // phase commands from the controller
    typedef struct packed {
        logic load;
        logic lookup;
        logic wchk;
        logic rscan;
    } t_cmd;

    // conditions reported back by the datapath
    typedef struct packed {
        t_kind kind;
        logic  idx_bad;
        logic  future;
        logic  cnt_zero;
        logic  hit;
        logic  k_zero;
    } t_stat;

endpackage

[src/sva_ram.sv]
module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sva_ctrl.sv]
module sva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sva_pkg::t_stat i_stat,
    output sva_pkg::t_cmd  o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    import sva_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_WCHK,
        S_RSCAN
    } t_state;

    t_state r_state;
    logic   r_done;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.lookup = (r_state == S_LOOKUP);
        o_cmd.wchk   = (r_state == S_WCHK);
        o_cmd.rscan  = (r_state == S_RSCAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    case (i_stat.kind)
                        KIND_WRITE: begin
                            if (i_stat.idx_bad || i_stat.cnt_zero) begin
                                r_state <= S_IDLE;
                                r_done  <= 1'b1;
                            end else begin
                                r_state <= S_WCHK;
                            end
                        end
                        KIND_READ: begin
                            if (i_stat.idx_bad || i_stat.future || i_stat.cnt_zero) begin
                                r_state <= S_IDLE;
                                r_done  <= 1'b1;
                            end else begin
                                r_state <= S_RSCAN;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end
                    endcase
                end
                S_WCHK: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                S_RSCAN: begin
                    // walk back one version a cycle until a match or the oldest
                    if (i_stat.hit || i_stat.k_zero) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[src/sva_dp.sv]
module sva_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sva_pkg::t_cmd                     i_cmd,
    input  logic [1:0]                        i_kind,
    input  logic [sva_pkg::IDX_BITS-1:0]      i_index,
    input  logic [sva_pkg::VALUE_BITS-1:0]    i_value,
    input  logic [sva_pkg::SNAP_BITS-1:0]     i_snap_id,
    input  logic [sva_pkg::LEN_BITS-1:0]      i_array_length,
    output sva_pkg::t_stat                    o_stat,
    output logic [sva_pkg::VALUE_BITS-1:0]    o_result,
    output logic [2:0]                        o_status
);

    import sva_pkg::*;

    t_kind                 r_kind;
    logic [IDX_BITS-1:0]   r_index;
    logic [VALUE_BITS-1:0] r_value;
    logic [SNAP_BITS-1:0]  r_sid;
    logic [SNAP_BITS-1:0]  r_counter, n_counter;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [VER_BITS-1:0]   r_k, n_k;
    logic [VALUE_BITS-1:0] r_result, n_result;
    logic [2:0]            r_status, n_status;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic                  set_valid;

    logic                  ct_we;
    logic [IDX_BITS-1:0]   ct_raddr;
    logic [CNT_BITS-1:0]   ct_wdata, ct_rdata;

    logic                  st_we;
    logic [SLOT_BITS-1:0]  st_waddr, st_raddr;
    logic [SLOT_W-1:0]     st_wdata, st_rdata;

    logic [CNT_BITS-1:0]   cnt_now, cnt_m1, rcnt_m1;
    logic [VER_BITS-1:0]   k_m1;
    logic [SNAP_BITS-1:0]  st_snap;
    logic [VALUE_BITS-1:0] st_val;
    logic                  idx_bad, future, sat, snap_match, full, hit;

    sva_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_ENTRIES)) u_count (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (r_index),
        .i_wdata (ct_wdata),
        .i_raddr (ct_raddr),
        .o_rdata (ct_rdata)
    );

    sva_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign ct_raddr = i_cmd.load ? i_index : r_index;

    always_comb begin
        // an entry never written holds no versions
        cnt_now    = r_valid[r_index] ? ct_rdata : '0;
        cnt_m1     = cnt_now - CNT_BITS'(1);
        rcnt_m1    = r_cnt - CNT_BITS'(1);
        k_m1       = r_k - VER_BITS'(1);
        st_snap    = st_rdata[SLOT_W-1:VALUE_BITS];
        st_val     = st_rdata[VALUE_BITS-1:0];
        idx_bad    = ({1'b0, r_index} >= i_array_length);
        future     = (r_sid >= r_counter);
        sat        = (r_counter == '1);
        snap_match = (st_snap == r_counter);
        full       = (r_cnt >= CNT_BITS'(MAX_VERSIONS));
        hit        = (st_snap <= r_sid);

        n_result  = r_result;
        n_status  = r_status;
        n_counter = r_counter;
        n_cnt     = r_cnt;
        n_k       = r_k;
        set_valid = 1'b0;
        ct_we     = 1'b0;
        ct_wdata  = cnt_now + CNT_BITS'(1);
        st_we     = 1'b0;
        st_waddr  = {r_index, cnt_now[VER_BITS-1:0]};
        st_wdata  = {r_counter, r_value};
        st_raddr  = {r_index, cnt_m1[VER_BITS-1:0]};

        if (i_cmd.lookup) begin
            n_cnt    = cnt_now;
            n_k      = cnt_m1[VER_BITS-1:0];
            n_result = '0;
            n_status = ST_OK;
            case (r_kind)
                KIND_WRITE: begin
                    if (idx_bad) begin
                        n_status = ST_BAD;
                    end else if (cnt_now == '0) begin
                        // first version: append at slot zero
                        st_we     = 1'b1;
                        ct_we     = 1'b1;
                        set_valid = 1'b1;
                    end
                end
                KIND_SNAP: begin
                    if (sat) begin
                        n_status = ST_SAT;
                    end else begin
                        n_result  = VALUE_BITS'(r_counter);
                        n_counter = r_counter + SNAP_BITS'(1);
                    end
                end
                KIND_READ: begin
                    if (idx_bad) begin
                        n_status = ST_BAD;
                    end else if (future) begin
                        n_status = ST_FUTURE;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end else if (i_cmd.wchk) begin
            n_result = '0;
            n_status = ST_OK;
            ct_wdata = r_cnt + CNT_BITS'(1);
            if (snap_match) begin
                // newest version has the current number: overwrite it
                st_we    = 1'b1;
                st_waddr = {r_index, rcnt_m1[VER_BITS-1:0]};
            end else if (full) begin
                n_status = ST_FULL;
            end else begin
                st_we     = 1'b1;
                st_waddr  = {r_index, r_cnt[VER_BITS-1:0]};
                ct_we     = 1'b1;
                set_valid = 1'b1;
            end
        end else if (i_cmd.rscan) begin
            n_status = ST_OK;
            st_raddr = {r_index, k_m1};
            n_k      = k_m1;
            n_result = hit ? st_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_kind);
            r_index <= i_index;
            r_value <= i_value;
            r_sid   <= i_snap_id;
        end
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_result <= n_result;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_valid   <= '0;
        end else begin
            r_counter <= n_counter;
            if (set_valid) begin
                r_valid[r_index] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.kind     = r_kind;
        o_stat.idx_bad  = idx_bad;
        o_stat.future   = future;
        o_stat.cnt_zero = (cnt_now == '0);
        o_stat.hit      = hit;
        o_stat.k_zero   = (r_k == '0);
    end

    assign o_result = r_result;
    assign o_status = r_status;

endmodule

[src/snapshot_versioned_array.sv]
// Versioned array with snapshots. Pulse start while busy is low to issue a
// request (write, snap, read); its result appears on o_result/o_status for
// exactly one cycle with o_done high and must be taken then, since the block
// cannot be stalled. A snap ends after the lookup state, a write after the
// lookup or write-check state, and a read after lookup plus one scan step per
// stored version it walks back over: the read scan steps through the version
// store one read per cycle on its single read port. A new request may be
// issued in the cycle o_done is high. array_length sits at byte address 0.
`include "snapshot_versioned_array_macros.svh"

module snapshot_versioned_array (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_kind,
    input  logic [sva_pkg::IDX_BITS-1:0]  i_index,
    input  logic signed [sva_pkg::VALUE_BITS-1:0] i_value,
    input  logic [sva_pkg::SNAP_BITS-1:0] i_snap_id,
    output logic                          o_done,
    output logic signed [sva_pkg::VALUE_BITS-1:0] o_result,
    output logic [2:0]                    o_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import sva_pkg::*;

    t_cmd                  cmd;
    t_stat                 stat;
    logic [LEN_BITS-1:0]   r_array_length;
    logic [VALUE_BITS-1:0] result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_length <= LEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_array_length <= pwdata[LEN_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? 32'(r_array_length) : '0;

    sva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    sva_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_snap_id      (i_snap_id),
        .i_array_length (r_array_length),
        .o_stat         (stat),
        .o_result       (result),
        .o_status       (o_status)
    );

    assign o_result = result;

    `SVA_ASSERT_NOW(a_done_when_idle, o_done, !busy)
    `SVA_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
    `SVA_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `SVA_ASSERT_NOW(a_fault_zero, o_done && (o_status != ST_OK), o_result == '0)

endmodule
